// File: hdl/sar_pkg.sv
// sar_pkg: shared types, codes and constants for the symbol address resolver.
// Used by every module of the block except sar_ram; depends on nothing.
package sar_pkg;

	localparam int SIDX_W = 11;
	localparam int DIST_W = 16;

	localparam logic [1:0] ADDR_SYMBOL_COUNT = 2'd0;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic [2:0] KIND_BOOT      = 3'd0;
	localparam logic [2:0] KIND_EXACT     = 3'd1;
	localparam logic [2:0] KIND_CLOSEST   = 3'd2;
	localparam logic [2:0] KIND_NULL      = 3'd3;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd4;

	localparam logic [63:0] BOOT_LOW       = 64'h7c00;
	localparam logic [63:0] BOOT_END       = 64'h7e00;
	localparam logic [63:0] FIRST_PAGE_END = 64'h1000;

	typedef struct packed {
		logic        action;
		logic [9:0]  entry_index;
		logic [63:0] entry_base;
		logic [63:0] entry_size;
		logic [31:0] entry_name_offset;
		logic [63:0] lookup_address;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [63:0] symbol_base;
		logic [31:0] symbol_offset;
		logic [9:0]  symbol_index;
		logic [31:0] name_offset;
	} rsp_t;

	typedef struct packed {
		logic        en;
		logic [9:0]  index;
		logic [63:0] base;
		logic [63:0] size;
		logic [31:0] name;
	} wr_req_t;

	// running best match handed along the cell chain
	typedef struct packed {
		logic              exact;
		logic [SIDX_W-1:0] ex_idx;
		logic [63:0]       ex_base;
		logic [31:0]       ex_name;
		logic              near;
		logic [SIDX_W-1:0] nr_idx;
		logic [63:0]       nr_base;
		logic [31:0]       nr_name;
		logic [DIST_W-1:0] nr_dist;
	} chain_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MERGE,
		ST_DONE
	} state_t;

endpackage

// File: hdl/sar_ram.sv
// sar_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module sar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/sar_cell.sv
// sar_cell: one cell of the search chain; owns one interleaved bank of the table,
// scans it and merges its best match with the one from its left neighbour.
// Depends on sar_pkg and sar_ram.
module sar_cell #(
	parameter int CELL_ID     = 0,
	parameter int NUM_CELLS   = 4,
	parameter int MAX_SYMBOLS = 1024,
	parameter int NEAR_WINDOW = 512,
	localparam int ROWS  = (MAX_SYMBOLS + NUM_CELLS - 1) / NUM_CELLS,
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       lookup_addr,
	input  logic [10:0]       count,
	input  sar_pkg::wr_req_t  wr,
	input  logic              rd_en,
	input  logic [ROW_W-1:0]  rd_row,
	input  sar_pkg::chain_t   left,
	output sar_pkg::chain_t   right
);

	localparam int EW = 160;

	logic                      wr_sel;
	logic [ROW_W-1:0]          wr_row;
	logic [EW-1:0]             rd_data;
	logic [31:0]               rd_idx;
	logic                      rd_ok;
	logic                      ok_s1;
	logic [sar_pkg::SIDX_W-1:0] idx_s1;
	logic                      ok_s2;
	logic [sar_pkg::SIDX_W-1:0] idx_s2;
	logic                      ge_s2;
	logic [63:0]               diff_s2;
	logic [63:0]               size_s2;
	logic [63:0]               base_s2;
	logic [31:0]               name_s2;
	logic                      exact_hit;
	logic                      near_hit;
	sar_pkg::chain_t           loc_q;
	sar_pkg::chain_t           right_q;

	function automatic sar_pkg::chain_t merge(input sar_pkg::chain_t l, input sar_pkg::chain_t m);
		sar_pkg::chain_t r;
		r = l;
		if (m.exact && (!l.exact || m.ex_idx < l.ex_idx)) begin
			r.exact   = 1'b1;
			r.ex_idx  = m.ex_idx;
			r.ex_base = m.ex_base;
			r.ex_name = m.ex_name;
		end
		if (m.near && (!l.near || m.nr_dist < l.nr_dist ||
				(m.nr_dist == l.nr_dist && m.nr_idx < l.nr_idx))) begin
			r.near    = 1'b1;
			r.nr_idx  = m.nr_idx;
			r.nr_base = m.nr_base;
			r.nr_name = m.nr_name;
			r.nr_dist = m.nr_dist;
		end
		return r;
	endfunction

	assign wr_sel = wr.en && ((32'(wr.index) % NUM_CELLS) == CELL_ID) &&
		(32'(wr.index) < MAX_SYMBOLS);
	assign wr_row = ROW_W'(32'(wr.index) / NUM_CELLS);

	sar_ram #(
		.WIDTH (EW),
		.DEPTH (ROWS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_sel),
		.wr_addr (wr_row),
		.wr_data ({wr.base, wr.size, wr.name}),
		.rd_en   (rd_en),
		.rd_addr (rd_row),
		.rd_data (rd_data)
	);

	assign rd_idx = 32'(rd_row) * NUM_CELLS + CELL_ID;
	assign rd_ok  = rd_en && (rd_idx < MAX_SYMBOLS) && (rd_idx < 32'(count));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_s1 <= 1'b0;
			ok_s2 <= 1'b0;
		end else begin
			ok_s1 <= rd_ok;
			ok_s2 <= ok_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= sar_pkg::SIDX_W'(rd_idx);
		idx_s2  <= idx_s1;
		ge_s2   <= lookup_addr >= rd_data[159:96];
		diff_s2 <= lookup_addr - rd_data[159:96];
		base_s2 <= rd_data[159:96];
		size_s2 <= rd_data[95:32];
		name_s2 <= rd_data[31:0];
	end

	assign exact_hit = ok_s2 && ge_s2 && (diff_s2 < size_s2);
	assign near_hit  = ok_s2 && ge_s2 && (diff_s2 < 64'(NEAR_WINDOW)) &&
		(!loc_q.near || sar_pkg::DIST_W'(diff_s2) < loc_q.nr_dist);

	// first exact hit in scan order; strictly closer near hit replaces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc_q <= '0;
		end else if (start) begin
			loc_q.exact <= 1'b0;
			loc_q.near  <= 1'b0;
		end else begin
			if (exact_hit && !loc_q.exact) begin
				loc_q.exact   <= 1'b1;
				loc_q.ex_idx  <= idx_s2;
				loc_q.ex_base <= base_s2;
				loc_q.ex_name <= name_s2;
			end
			if (near_hit) begin
				loc_q.near    <= 1'b1;
				loc_q.nr_idx  <= idx_s2;
				loc_q.nr_base <= base_s2;
				loc_q.nr_name <= name_s2;
				loc_q.nr_dist <= sar_pkg::DIST_W'(diff_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q <= '0;
		end else begin
			right_q <= merge(left, loc_q);
		end
	end

	assign right = right_q;

endmodule

// File: hdl/symbol_address_resolver_core.sv
// symbol_address_resolver_core: top level of the symbol address resolver.
// Depends on sar_pkg, sar_cell and sar_ram.
//
// Resolves code addresses against a table of symbols spread over NUM_CELLS cells, slot i
// living in cell i mod NUM_CELLS. A write transaction fills one slot. A lookup outside the
// table search (boot area, zero, low addresses) is resolved without a scan and loaded into
// its result register. A lookup that searches the table sweeps all ROWS rows,
// ROWS = ceil(MAX_SYMBOLS / NUM_CELLS) (256 at the defaults): each cell sweeps its bank
// through its single RAM read port, one row a cycle, then the per-cell best matches ripple
// down the chain one cell a cycle. Only one transaction is worked at a time; a finished
// result waits in the output register while the next transaction is taken. Table contents
// are undefined until written; symbol_count is at 0 after reset.
module symbol_address_resolver_core #(
	parameter int MAX_SYMBOLS = 1024,
	parameter int NEAR_WINDOW = 512,
	parameter int NUM_CELLS   = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          req_valid,
	output logic          req_ready,
	input  sar_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sar_pkg::rsp_t rsp
);

	localparam int ROWS   = (MAX_SYMBOLS + NUM_CELLS - 1) / NUM_CELLS;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int WAIT   = NUM_CELLS + 3;
	localparam int WAIT_W = $clog2(WAIT + 1);

	sar_pkg::state_t  state_q;
	sar_pkg::state_t  state_d;
	logic [10:0]      count_q;
	logic [63:0]      addr_q;
	logic [ROW_W-1:0] row_q;
	logic [WAIT_W-1:0] wait_q;
	logic             rsp_valid_q;
	sar_pkg::rsp_t    rsp_q;
	sar_pkg::rsp_t    res;
	sar_pkg::wr_req_t wr;
	sar_pkg::chain_t  chain [NUM_CELLS + 1];
	sar_pkg::chain_t  best;
	logic             accept;
	logic             start;
	logic             rd_en;
	logic             load_rsp;
	logic             needs_scan;
	logic             in_boot;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (psel && penable && pwrite && pready &&
				paddr == sar_pkg::ADDR_SYMBOL_COUNT) begin
			count_q <= pwdata[10:0];
		end
	end

	always_comb begin
		if (paddr == sar_pkg::ADDR_SYMBOL_COUNT) begin
			prdata = 32'(count_q);
		end else begin
			prdata = '0;
		end
	end

	assign accept = req_valid && req_ready;

	assign wr.en    = accept && req.action == sar_pkg::ACT_WRITE;
	assign wr.index = req.entry_index;
	assign wr.base  = req.entry_base;
	assign wr.size  = req.entry_size;
	assign wr.name  = req.entry_name_offset;

	assign in_boot = req.lookup_address >= sar_pkg::BOOT_LOW &&
		req.lookup_address < sar_pkg::BOOT_END;
	assign needs_scan = !in_boot && req.lookup_address > sar_pkg::FIRST_PAGE_END;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sar_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		start     = 1'b0;
		rd_en     = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			sar_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid && req.action == sar_pkg::ACT_LOOKUP) begin
					start = 1'b1;
					if (needs_scan) begin
						state_d = sar_pkg::ST_SCAN;
					end else begin
						state_d = sar_pkg::ST_DONE;
					end
				end
			end
			sar_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (row_q == ROW_W'(ROWS - 1)) begin
					state_d = sar_pkg::ST_MERGE;
				end
			end
			sar_pkg::ST_MERGE: begin
				if (wait_q == WAIT_W'(WAIT - 1)) begin
					state_d = sar_pkg::ST_DONE;
				end
			end
			sar_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = sar_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sar_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			wait_q <= '0;
		end else begin
			if (start) begin
				row_q <= '0;
			end else if (rd_en) begin
				row_q <= row_q + ROW_W'(1);
			end
			if (state_q == sar_pkg::ST_MERGE) begin
				wait_q <= wait_q + WAIT_W'(1);
			end else begin
				wait_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= req.lookup_address;
		end
	end

	assign chain[0] = '0;

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		sar_cell #(
			.CELL_ID     (c),
			.NUM_CELLS   (NUM_CELLS),
			.MAX_SYMBOLS (MAX_SYMBOLS),
			.NEAR_WINDOW (NEAR_WINDOW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.start       (start),
			.lookup_addr (addr_q),
			.count       (count_q),
			.wr          (wr),
			.rd_en       (rd_en),
			.rd_row      (row_q),
			.left        (chain[c]),
			.right       (chain[c + 1])
		);
	end

	assign best = chain[NUM_CELLS];

	always_comb begin
		res.result_kind   = sar_pkg::KIND_NOT_FOUND;
		res.symbol_base   = addr_q;
		res.symbol_offset = '0;
		res.symbol_index  = '0;
		res.name_offset   = '0;
		if (addr_q >= sar_pkg::BOOT_LOW && addr_q < sar_pkg::BOOT_END) begin
			res.result_kind   = sar_pkg::KIND_BOOT;
			res.symbol_base   = sar_pkg::BOOT_LOW;
			res.symbol_offset = 32'(addr_q - sar_pkg::BOOT_LOW);
		end else if (addr_q > sar_pkg::FIRST_PAGE_END) begin
			if (best.exact) begin
				res.result_kind   = sar_pkg::KIND_EXACT;
				res.symbol_base   = best.ex_base;
				res.symbol_offset = 32'(addr_q - best.ex_base);
				res.symbol_index  = 10'(best.ex_idx);
				res.name_offset   = best.ex_name;
			end else if (best.near) begin
				res.result_kind   = sar_pkg::KIND_CLOSEST;
				res.symbol_base   = best.nr_base;
				res.symbol_offset = 32'(addr_q - best.nr_base);
				res.symbol_index  = 10'(best.nr_idx);
				res.name_offset   = best.nr_name;
			end
		end else if (addr_q == '0) begin
			res.result_kind = sar_pkg::KIND_NULL;
			res.symbol_base = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hdl/sar_checker.sv
// sar_checker: port-level checks on the resolver's result channel and register port,
// bound to symbol_address_resolver_core. Depends on sar_pkg.
module sar_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          pready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input sar_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result transaction dropped or changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_boot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == sar_pkg::KIND_BOOT |->
		rsp.symbol_base == sar_pkg::BOOT_LOW && rsp.symbol_offset < 32'h200 &&
		rsp.symbol_index == '0 && rsp.name_offset == '0)
		else $error("malformed boot area result");

	a_null: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == sar_pkg::KIND_NULL |->
		rsp.symbol_base == '0 && rsp.symbol_offset == '0 &&
		rsp.symbol_index == '0 && rsp.name_offset == '0)
		else $error("malformed null result");

	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == sar_pkg::KIND_NOT_FOUND |->
		rsp.symbol_offset == '0 && rsp.symbol_index == '0 && rsp.name_offset == '0 &&
		rsp.symbol_base != '0)
		else $error("malformed not-found result");

endmodule

bind symbol_address_resolver_core sar_checker u_sar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// File: tb/symbol_address_resolver_core_tb.sv
`timescale 1ns / 100ps
// symbol_address_resolver_core_tb: self-checking testbench for the symbol address resolver.
// Drives table writes, lookups and symbol_count writes, predicting each result as it is sent.
// Depends on sar_pkg and symbol_address_resolver_core.
module symbol_address_resolver_core_tb;

	localparam int TABLE_DEPTH = 1024;
	localparam logic [63:0] NEAR_SPAN = 64'd512;
	localparam int SETTLE_CYCLES = 300;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [1:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;
	logic          req_valid;
	logic          req_ready;
	sar_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	sar_pkg::rsp_t rsp;

	// shadow copy of the symbol table and its count
	logic [63:0]   sym_base [TABLE_DEPTH];
	logic [63:0]   sym_size [TABLE_DEPTH];
	logic [31:0]   sym_label [TABLE_DEPTH];
	logic [10:0]   sym_count = '0;
	sar_pkg::rsp_t pending_lookups [$];
	logic [63:0]   cluster_base = 64'h2000;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int errors = 0;

	symbol_address_resolver_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", field, got, want));
	endtask

	function automatic sar_pkg::rsp_t resolve_address(input logic [63:0] addr);
		sar_pkg::rsp_t res;
		int            live;
		int            hit;
		logic [63:0]   gap;
		logic [63:0]   best_gap;
		res = '0;
		live = (sym_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sym_count);
		hit = -1;
		best_gap = NEAR_SPAN;
		if (addr >= sar_pkg::BOOT_LOW && addr < sar_pkg::BOOT_END) begin
			res.result_kind = sar_pkg::KIND_BOOT;
			res.symbol_base = sar_pkg::BOOT_LOW;
			res.symbol_offset = 32'(addr - sar_pkg::BOOT_LOW);
			return res;
		end
		if (addr == '0) begin
			res.result_kind = sar_pkg::KIND_NULL;
			return res;
		end
		res.result_kind = sar_pkg::KIND_NOT_FOUND;
		res.symbol_base = addr;
		if (addr <= sar_pkg::FIRST_PAGE_END)
			return res;
		// containment and distance both tested without forming base + size
		for (int i = 0; i < live && hit < 0; i++)
			if (addr >= sym_base[i] && addr - sym_base[i] < sym_size[i])
				hit = i;
		if (hit >= 0) begin
			res.result_kind = sar_pkg::KIND_EXACT;
		end else begin
			for (int i = 0; i < live; i++) begin
				gap = addr - sym_base[i];
				if (addr >= sym_base[i] && gap < best_gap) begin
					best_gap = gap;
					hit = i;
				end
			end
			if (hit >= 0)
				res.result_kind = sar_pkg::KIND_CLOSEST;
		end
		if (hit >= 0) begin
			res.symbol_base = sym_base[hit];
			res.symbol_offset = 32'(addr - sym_base[hit]);
			res.symbol_index = 10'(hit);
			res.name_offset = sym_label[hit];
		end
		return res;
	endfunction

	// table update and prediction on each accepted transaction, checking on each result
	always @(posedge clk) begin : track
		sar_pkg::rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				if (req.action == sar_pkg::ACT_WRITE) begin
					sym_base[req.entry_index] = req.entry_base;
					sym_size[req.entry_index] = req.entry_size;
					sym_label[req.entry_index] = req.entry_name_offset;
				end else begin
					pending_lookups.push_back(resolve_address(req.lookup_address));
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_lookups.size() == 0) begin
					report_mismatch("result with no lookup outstanding");
				end else begin
					want = pending_lookups.pop_front();
					check_field("result_kind", 64'(rsp.result_kind), 64'(want.result_kind));
					check_field("symbol_base", rsp.symbol_base, want.symbol_base);
					check_field("symbol_offset", 64'(rsp.symbol_offset),
						64'(want.symbol_offset));
					check_field("symbol_index", 64'(rsp.symbol_index),
						64'(want.symbol_index));
					check_field("name_offset", 64'(rsp.name_offset), 64'(want.name_offset));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
				|| (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
			$display("symbol_address_resolver_core_tb: errors");
			$finish;
		end
	end

	task automatic send_item(input sar_pkg::req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	// sender pauses until every result is back, then lets a trailing write settle
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_symbol_count(input logic [10:0] value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= sar_pkg::ADDR_SYMBOL_COUNT;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sym_count = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[10:0] !== value)
			report_mismatch($sformatf("symbol_count read %h expected %h", prdata, value));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic sar_pkg::req_t entry_fixed(input logic [9:0] slot,
			input logic [63:0] base, input logic [63:0] size, input logic [31:0] name);
		sar_pkg::req_t item;
		item.action = sar_pkg::ACT_WRITE;
		item.entry_index = slot;
		item.entry_base = base;
		item.entry_size = size;
		item.entry_name_offset = name;
		item.lookup_address = rand64();
		return item;
	endfunction

	function automatic sar_pkg::req_t entry_item(input logic [9:0] slot);
		int          pick;
		logic [63:0] size;
		pick = $urandom_range(99);
		if (pick < 60)
			size = 64'($urandom_range(0, 32'h200));
		else if (pick < 72)
			size = '0;
		else if (pick < 82)
			size = rand64();
		else if (pick < 90)
			size = '1;
		else
			size = 64'($urandom_range(0, 32'h2000));
		return entry_fixed(slot, cluster_base + 64'($urandom_range(0, 32'h3000)), size,
			$urandom);
	endfunction

	function automatic sar_pkg::req_t lookup_item(input logic [63:0] addr);
		sar_pkg::req_t item;
		item.action = sar_pkg::ACT_LOOKUP;
		item.entry_index = 10'($urandom);
		item.entry_base = rand64();
		item.entry_size = rand64();
		item.entry_name_offset = $urandom;
		item.lookup_address = addr;
		return item;
	endfunction

	// addresses that never reach the table
	function automatic logic [63:0] quick_address();
		case ($urandom_range(2))
			0: return '0;
			1: return 64'($urandom_range(1, 32'h1000));
			default: return sar_pkg::BOOT_LOW + 64'($urandom_range(0, 32'h1ff));
		endcase
	endfunction

	function automatic logic [63:0] random_address();
		int          pick;
		int          live;
		logic [63:0] b;
		live = (sym_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sym_count);
		pick = $urandom_range(99);
		if (live > 0 && pick < 55) begin
			b = sym_base[$urandom_range(0, live - 1)];
			return (pick < 45) ? b + 64'($urandom_range(0, 32'h300)) :
				b - 64'($urandom_range(1, 32'h100));
		end
		if (pick < 70)
			return cluster_base + 64'($urandom_range(0, 32'h4000));
		if (pick < 80)
			return rand64();
		if (pick < 94)
			return quick_address();
		case ($urandom_range(3))
			0: return sar_pkg::BOOT_LOW - 64'd1;
			1: return sar_pkg::BOOT_END;
			2: return sar_pkg::FIRST_PAGE_END;
			default: return sar_pkg::FIRST_PAGE_END + 64'd1;
		endcase
	endfunction

	task automatic fill_table(input int n);
		for (int i = 0; i < n; i++)
			send_item(entry_item(10'(i)));
	endtask

	// boundaries of the boot area, the first page and zero, with an empty search
	task automatic test_special_addresses();
		logic [63:0] probes [9] = '{64'h0, 64'h1, 64'h1000, 64'h1001, 64'h7bff,
			64'h7c00, 64'h7dff, 64'h7e00, 64'hffff_ffff_ffff_ffff};
		set_symbol_count(11'd0);
		foreach (probes[i])
			send_item(lookup_item(probes[i]));
	endtask

	// overlaps, ties, zero size, wrapping range, long offsets, boot overlap
	task automatic test_directed_table();
		logic [63:0] probes [11] = '{64'h2000, 64'h2090, 64'h2200, 64'h3000, 64'h3200,
			64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_feff, 64'h2_2345_6789,
			64'h7c90, 64'h7e10, 64'h9005};
		cluster_base = 64'h2000;
		send_item(entry_fixed(10'd0, 64'h2000, 64'h100, 32'h0));
		send_item(entry_fixed(10'd1, 64'h2080, 64'h100, 32'hffff_ffff));
		send_item(entry_fixed(10'd2, 64'hffff_ffff_ffff_ff00, '1, 32'h1234));
		send_item(entry_fixed(10'd3, 64'h3000, 64'h0, 32'h55));
		send_item(entry_fixed(10'd4, 64'h3000, 64'h0, 32'h66));
		send_item(entry_fixed(10'd5, 64'h1_0000_0000, 64'h100_0000_0000, 32'haaaa));
		send_item(entry_fixed(10'd6, 64'h7c80, 64'h100, 32'h7));
		send_item(entry_fixed(10'd1023, 64'h9000, 64'h10, 32'h3ff));
		set_symbol_count(11'd7);
		foreach (probes[i])
			send_item(lookup_item(probes[i]));
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input int count,
			input int items, input logic [63:0] cluster);
		send_idle_pct = idle;
		stall_pct = stall;
		cluster_base = cluster;
		fill_table(count);
		set_symbol_count(11'(count));
		repeat (items) begin
			if ($urandom_range(99) < 80)
				send_item(lookup_item(random_address()));
			else
				send_item(entry_item(10'($urandom)));
		end
	endtask

	// results held back long enough for the block to stall its input
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		wait_idle();
		hold_left = HOLD_CYCLES;
		repeat (12) begin
			if ($urandom_range(3) == 0)
				send_item(entry_item(10'($urandom_range(512, 1023))));
			else
				send_item(lookup_item(quick_address()));
		end
		wait_idle();
	endtask

	// every slot written, then counts just below, at and above the table size, and zero
	task automatic test_full_table();
		logic [10:0] counts [4] = '{11'd1023, 11'd1024, 11'd2047, 11'd0};
		logic [63:0] far_base;
		send_idle_pct = 0;
		stall_pct = 31;
		cluster_base = rand64() & ~64'hf_ffff;
		far_base = cluster_base + 64'h10_0000;
		fill_table(TABLE_DEPTH - 1);
		send_item(entry_fixed(10'd1023, far_base, 64'h100, $urandom));
		foreach (counts[i]) begin
			set_symbol_count(counts[i]);
			send_item(lookup_item(far_base + 64'h10));
			send_item(lookup_item(far_base + 64'h150));
			repeat (8)
				send_item(lookup_item(random_address()));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_addresses();
		test_directed_table();
		test_random_traffic(0, 0, 16, 130, rand64() & ~64'hf_ffff);
		test_random_traffic(68, 0, $urandom_range(1, 24), 130, 64'h6000);
		test_random_traffic(0, 68, $urandom_range(8, 48), 130, 64'hffff_ffff_ffff_c000);
		test_random_traffic(31, 31, 1, 130, rand64() & ~64'hf_ffff);
		test_backpressure();
		test_full_table();

		wait_idle();
		if (errors == 0)
			$display("symbol_address_resolver_core_tb: clean");
		else
			$display("symbol_address_resolver_core_tb: errors");
		$finish;
	end

endmodule

// File: symbol_address_resolver_core.f
hdl/sar_pkg.sv
hdl/sar_ram.sv
hdl/sar_cell.sv
hdl/symbol_address_resolver_core.sv
hdl/sar_checker.sv
tb/symbol_address_resolver_core_tb.sv
